// ===== rtl/lhbe_pkg.sv =====
// lhbe_pkg: shared widths, limits and the burst command type
// used by the front classifier, the command queue and the result expander
// no dependencies
package lhbe_pkg;

   localparam int MAX_LINES   = 64;
   localparam int HEIGHT_W    = 16;
   localparam int LEN_W       = 7;
   localparam int IDX_W       = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // one burst: a closed block, then optionally the list's final block
   typedef struct packed {
      logic [HEIGHT_W-1:0] max1;
      logic [LEN_W-1:0]    len1;
      logic [HEIGHT_W-1:0] max2;
      logic [LEN_W-1:0]    len2;
      logic [IDX_W-1:0]    start_idx;
      logic                final_list;
      logic                ovf;
   } cmd_type;

endpackage

// ===== rtl/lhbe_front.sv =====
// lhbe_front: takes line heights, tracks the open block and emits burst commands
// depends on lhbe_pkg
module lhbe_front
   import lhbe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [HEIGHT_W-1:0] height,
   input  logic                last,
   output logic                cmd_push,
   output cmd_type             cmd
);

   logic [HEIGHT_W-1:0] prev_ff, prev_in;
   logic [HEIGHT_W-1:0] bmin_ff, bmin_in;
   logic [HEIGHT_W-1:0] bmax_ff, bmax_in;
   logic [LEN_W-1:0]    blen_ff, blen_in;
   logic [LEN_W-1:0]    ecnt_ff, ecnt_in;
   logic [LEN_W-1:0]    llen_ff, llen_in;
   logic                started_ff, started_in;
   logic                dropped_ff, dropped_in;

   logic [HEIGHT_W-1:0] seg1_max;
   logic [LEN_W-1:0]    seg1_len;
   logic                split;

   // height outside [ref/2, 2*ref]
   function automatic logic out_of_band(input logic [HEIGHT_W-1:0] h,
                                        input logic [HEIGHT_W-1:0] r);
      logic [HEIGHT_W:0] h2;
      logic [HEIGHT_W:0] r2;
      h2 = {h, 1'b0};
      r2 = {r, 1'b0};
      return ({1'b0, h} > r2) || (h2 < {1'b0, r});
   endfunction

   // classification and next block state
   always_comb begin
      prev_in    = prev_ff;
      bmin_in    = bmin_ff;
      bmax_in    = bmax_ff;
      blen_in    = blen_ff;
      ecnt_in    = ecnt_ff;
      llen_in    = llen_ff;
      started_in = started_ff;
      dropped_in = dropped_ff;
      seg1_max   = bmax_ff;
      seg1_len   = '0;
      split      = out_of_band(height, prev_ff) ||
                   ((bmin_ff != '0) && out_of_band(height, bmin_ff));
      cmd        = '0;

      if (!started_ff) begin
         started_in = 1'b1;
         bmin_in    = height;
         bmax_in    = height;
         blen_in    = LEN_W'(1);
         prev_in    = height;
         llen_in    = LEN_W'(1);
      end else if (llen_ff >= LEN_W'(MAX_LINES)) begin
         dropped_in = 1'b1;
      end else begin
         if (split) begin
            seg1_len = blen_ff;
            ecnt_in  = ecnt_ff + blen_ff;
            bmin_in  = height;
            bmax_in  = height;
            blen_in  = LEN_W'(1);
         end else begin
            if (height < bmin_ff) bmin_in = height;
            if (height > bmax_ff) bmax_in = height;
            blen_in = blen_ff + LEN_W'(1);
         end
         prev_in = height;
         llen_in = llen_ff + LEN_W'(1);
      end

      cmd.max1       = seg1_max;
      cmd.len1       = seg1_len;
      cmd.start_idx  = ecnt_ff[IDX_W-1:0];
      cmd.max2       = bmax_in;

      // end of list: flush the open block and return to the reset state
      if (last) begin
         cmd.len2       = blen_in;
         cmd.final_list = 1'b1;
         cmd.ovf        = dropped_in;
         prev_in    = '0;
         bmin_in    = '0;
         bmax_in    = '0;
         blen_in    = '0;
         ecnt_in    = '0;
         llen_in    = '0;
         started_in = 1'b0;
         dropped_in = 1'b0;
      end

      cmd_push = accept && ((seg1_len != '0) || last);
   end

   // block state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         bmin_ff    <= '0;
         bmax_ff    <= '0;
         blen_ff    <= '0;
         ecnt_ff    <= '0;
         llen_ff    <= '0;
         started_ff <= 1'b0;
         dropped_ff <= 1'b0;
      end else if (accept) begin
         prev_ff    <= prev_in;
         bmin_ff    <= bmin_in;
         bmax_ff    <= bmax_in;
         blen_ff    <= blen_in;
         ecnt_ff    <= ecnt_in;
         llen_ff    <= llen_in;
         started_ff <= started_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

// ===== rtl/lhbe_queue.sv =====
// lhbe_queue: short command queue between the front and the result expander
// depends on lhbe_pkg
module lhbe_queue
   import lhbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    full,
   output logic    empty
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// ===== rtl/lhbe_back.sv =====
// lhbe_back: expands burst commands into one result per line, with an output register
// depends on lhbe_pkg
module lhbe_back
   import lhbe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  cmd_type             q_data,
   output logic                q_pop,
   input  logic                pop,
   output logic                empty,
   output logic [HEIGHT_W-1:0] new_height,
   output logic [IDX_W-1:0]    line_index,
   output logic                last_res,
   output logic                overflow
);

   logic                busy_ff, busy_in;
   logic [HEIGHT_W-1:0] max1_ff, max2_ff;
   logic [LEN_W-1:0]    rem1_ff, rem1_in;
   logic [LEN_W-1:0]    rem2_ff, rem2_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                final_ff, ovf_ff;
   logic                out_valid_ff, out_valid_in;
   logic [HEIGHT_W-1:0] out_height_ff;
   logic [IDX_W-1:0]    out_idx_ff;
   logic                out_last_ff, out_ovf_ff;
   logic                take;
   logic                last_one;

   assign q_pop      = !busy_ff && !q_empty;
   assign take       = busy_ff && (!out_valid_ff || pop);
   assign last_one   = ((rem1_ff == '0) && (rem2_ff == LEN_W'(1))) ||
                       ((rem1_ff == LEN_W'(1)) && (rem2_ff == '0));
   assign empty      = !out_valid_ff;
   assign new_height = out_height_ff;
   assign line_index = out_idx_ff;
   assign last_res   = out_last_ff;
   assign overflow   = out_ovf_ff;

   // burst counters
   always_comb begin
      rem1_in      = rem1_ff;
      rem2_in      = rem2_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      if (take) begin
         if (rem1_ff != '0) rem1_in = rem1_ff - LEN_W'(1);
         else               rem2_in = rem2_ff - LEN_W'(1);
         idx_in       = idx_ff + IDX_W'(1);
         busy_in      = !last_one;
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         busy_ff      <= q_pop ? 1'b1 : busy_in;
      end
   end

   // command and result registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         max1_ff  <= q_data.max1;
         rem1_ff  <= q_data.len1;
         max2_ff  <= q_data.max2;
         rem2_ff  <= q_data.len2;
         idx_ff   <= q_data.start_idx;
         final_ff <= q_data.final_list;
         ovf_ff   <= q_data.ovf;
      end else begin
         rem1_ff <= rem1_in;
         rem2_ff <= rem2_in;
         idx_ff  <= idx_in;
      end
      if (take) begin
         out_height_ff <= (rem1_ff != '0) ? max1_ff : max2_ff;
         out_idx_ff    <= idx_ff;
         out_last_ff   <= final_ff && last_one;
         out_ovf_ff    <= final_ff && last_one && ovf_ff;
      end
   end

`ifndef SYNTH
   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((rem1_ff != '0) || (rem2_ff != '0)))
      else $error("expander busy with no lines left");
   a_ovf_on_final: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ovf_ff) |-> out_last_ff)
      else $error("overflow flagged on a non-final result");
   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (take && last_one) |=> !busy_ff)
      else $error("expander still busy after last line of burst");
`endif

endmodule

// ===== rtl/line_height_block_equalizer_core.sv =====
// line_height_block_equalizer_core: top level, front classifier, command queue, expander
// depends on lhbe_pkg, lhbe_front, lhbe_queue, lhbe_back

// Line heights enter one per cycle through push/full while the four-entry
// command queue has room; the front decides block splits in the same cycle
// and queues at most one burst command per height. The expander sends one
// result per cycle through empty/pop while pop is held, pausing between
// bursts as it loads its next command. Heights past MAX_LINES (64) in a
// list are dropped and flagged by overflow on the list's final result,
// which also carries last_res.
module line_height_block_equalizer_core
   import lhbe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [HEIGHT_W-1:0] req_height,
   input  logic                req_last,
   output logic                empty,
   input  logic                pop,
   output logic [HEIGHT_W-1:0] rsp_new_height,
   output logic [IDX_W-1:0]    rsp_line_index,
   output logic                rsp_last_res,
   output logic                rsp_overflow
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type q_data;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   assign full   = q_full;
   assign accept = push && !q_full;

   // height classification
   lhbe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .height   (req_height),
      .last     (req_last),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   // burst command queue
   lhbe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   // result expansion
   lhbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .new_height (rsp_new_height),
      .line_index (rsp_line_index),
      .last_res   (rsp_last_res),
      .overflow   (rsp_overflow)
   );

endmodule

// ===== tb/sv/line_height_block_equalizer_core_test.sv =====
// line_height_block_equalizer_core_test: self-checking testbench for the line height equalizer
// drives height lists through push/full, checks every equalized line through empty/pop
// depends on lhbe_pkg and line_height_block_equalizer_core
`timescale 1ns / 1ps

module line_height_block_equalizer_core_test
   import lhbe_pkg::*;
();

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 7;
   localparam int IDLE_PCT     = 33;
   localparam int RANDOM_ITEMS = 145;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic [HEIGHT_W-1:0] new_height;
      logic [IDX_W-1:0]    line_index;
      logic                last_res;
      logic                overflow;
   } line_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [HEIGHT_W-1:0] req_height = '0;
   logic                req_last = 1'b0;
   logic                empty;
   logic                pop = 1'b0;
   logic [HEIGHT_W-1:0] rsp_new_height;
   logic [IDX_W-1:0]    rsp_line_index;
   logic                rsp_last_res;
   logic                rsp_overflow;

   // equalized lines still owed by the block, oldest first
   line_result_type expected_lines[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   bit              steady = 1'b0;

   // predictor copy of the grouping state
   logic [HEIGHT_W-1:0] prev_h = '0;
   logic [HEIGHT_W-1:0] blk_min = '0;
   logic [HEIGHT_W-1:0] blk_max = '0;
   int                  blk_len = 0;
   int                  out_count = 0;
   int                  list_len = 0;
   bit                  list_open = 1'b0;
   bit                  list_dropped = 1'b0;

   line_height_block_equalizer_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_height     (req_height),
      .req_last       (req_last),
      .empty          (empty),
      .pop            (pop),
      .rsp_new_height (rsp_new_height),
      .rsp_line_index (rsp_line_index),
      .rsp_last_res   (rsp_last_res),
      .rsp_overflow   (rsp_overflow)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("line_height_block_equalizer_core_test failed");
         $finish;
      end
   end

   // result side stalls
   always @(negedge clock) begin
      pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // height lies outside [ref/2, 2*ref]
   function automatic bit beyond_band(input int h, input int ref_h);
      return (h > 2 * ref_h) || (2 * h < ref_h);
   endfunction

   // emit the open block's maximum once per line
   task automatic flush_block_lines(inout int burst);
      int              k;
      line_result_type line;
      for (k = 0; k < blk_len && burst < MAX_LINES; k++) begin
         line.new_height = blk_max;
         line.line_index = out_count[IDX_W-1:0];
         line.last_res   = 1'b0;
         line.overflow   = 1'b0;
         expected_lines  = {expected_lines, line};
         out_count = (out_count + 1) & 7'h7f;
         burst++;
      end
      blk_len = 0;
   endtask

   // expected lines caused by one accepted height
   task automatic predict_equalized(input logic [HEIGHT_W-1:0] h, input logic lst);
      int              burst;
      line_result_type tail;
      burst = 0;
      if (!list_open) begin
         list_open = 1'b1;
         blk_min   = h;
         blk_max   = h;
         blk_len   = 1;
         prev_h    = h;
         list_len  = 1;
      end else if (list_len >= MAX_LINES) begin
         list_dropped = 1'b1;
      end else begin
         if (beyond_band(int'(h), int'(prev_h)) ||
             (blk_min != 0 && beyond_band(int'(h), int'(blk_min)))) begin
            flush_block_lines(burst);
            blk_min = h;
            blk_max = h;
            blk_len = 1;
         end else begin
            if (h < blk_min) blk_min = h;
            if (h > blk_max) blk_max = h;
            blk_len++;
         end
         prev_h = h;
         list_len++;
      end
      // end of list: flush, mark the final line, start over
      if (lst) begin
         flush_block_lines(burst);
         if (burst > 0) begin
            tail = expected_lines.pop_back();
            tail.last_res = 1'b1;
            tail.overflow = list_dropped;
            expected_lines = {expected_lines, tail};
         end
         prev_h       = '0;
         blk_min      = '0;
         blk_max      = '0;
         blk_len      = 0;
         out_count    = 0;
         list_len     = 0;
         list_open    = 1'b0;
         list_dropped = 1'b0;
      end
   endtask

   // send one height, wait for acceptance, predict; called right after a falling edge
   task automatic send_line(input logic [HEIGHT_W-1:0] h, input logic lst);
      bit accepted;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         push = 1'b0;
         @(negedge clock);
      end
      push       = 1'b1;
      req_height = h;
      req_last   = lst;
      accepted   = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = !full;
      end
      predict_equalized(h, lst);
      @(negedge clock);
   endtask

   // compare each popped line with the oldest expectation
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && pop && !empty) begin
         if (expected_lines.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected line: height %0d index %0d last %0b ovf %0b",
                        rsp_new_height, rsp_line_index, rsp_last_res, rsp_overflow);
         end else begin
            want = expected_lines.pop_front();
            if (want.new_height !== rsp_new_height || want.line_index !== rsp_line_index ||
                want.last_res !== rsp_last_res || want.overflow !== rsp_overflow) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("line mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                           want.new_height, want.line_index, want.last_res, want.overflow,
                           rsp_new_height, rsp_line_index, rsp_last_res, rsp_overflow);
            end
         end
      end
   end

   // next height of a list: mostly inside the band, sometimes at its edges or far off
   function automatic logic [HEIGHT_W-1:0] pick_height(input logic [HEIGHT_W-1:0] p);
      int lo, hi, mode;
      lo   = (p + 1) / 2;
      hi   = (2 * p > 65535) ? 65535 : 2 * p;
      mode = $urandom_range(0, 99);
      if (mode < 60)
         return HEIGHT_W'($urandom_range(hi, lo));
      else if (mode < 75) begin
         case ($urandom_range(0, 3))
            0: return HEIGHT_W'((lo > 0) ? lo - 1 : 0);
            1: return HEIGHT_W'(lo);
            2: return HEIGHT_W'(hi);
            default: return HEIGHT_W'((hi < 65535) ? hi + 1 : 65535);
         endcase
      end else if (mode < 90)
         return HEIGHT_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
      else if (mode < 95)
         return '0;
      else
         return 16'hffff;
   endfunction

   task automatic test_single_line_lists();
      send_line(16'd100, 1'b1);
      send_line(16'd0, 1'b1);
      send_line(16'hffff, 1'b1);
   endtask

   // splits against previous height and block minimum at the exact band limits
   task automatic test_band_edges();
      send_line(16'd100, 1'b0);
      send_line(16'd200, 1'b0);
      send_line(16'd100, 1'b0);
      send_line(16'd49, 1'b0);
      send_line(16'd98, 1'b1);
      send_line(16'd100, 1'b0);
      send_line(16'd150, 1'b0);
      send_line(16'd210, 1'b1);
   endtask

   // zero previous height and zero block minimum
   task automatic test_zero_heights();
      send_line(16'd0, 1'b0);
      send_line(16'd0, 1'b0);
      send_line(16'd5, 1'b0);
      send_line(16'd0, 1'b0);
      send_line(16'd3, 1'b1);
   endtask

   task automatic test_extreme_heights();
      send_line(16'hffff, 1'b0);
      send_line(16'hffff, 1'b0);
      send_line(16'h8000, 1'b0);
      send_line(16'h7fff, 1'b0);
      send_line(16'hfffe, 1'b1);
   endtask

   // full lists, the largest burst, and dropped heights
   task automatic test_overflow_lists();
      int                  i;
      logic [HEIGHT_W-1:0] h;
      h = HEIGHT_W'($urandom_range(1, 65535));
      for (i = 0; i < MAX_LINES; i++)
         send_line(h, i == MAX_LINES - 1);
      for (i = 0; i < MAX_LINES - 1; i++)
         send_line(16'd1000, 1'b0);
      send_line(16'd5000, 1'b1);
      h = HEIGHT_W'($urandom_range(1, 65535));
      for (i = 0; i < 70; i++) begin
         h = pick_height(h);
         send_line(h, i == 69);
      end
      for (i = 0; i < 66; i++)
         send_line((i < 30) ? 16'd20 : 16'd300, i == 65);
   endtask

   // random lists, mostly short, a few past the line limit
   task automatic test_random_lists();
      int                  sent, len, i, r;
      logic [HEIGHT_W-1:0] h;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = (sent >= 40 && sent < 115);
         r = $urandom_range(0, 99);
         if (r < 80)
            len = $urandom_range(1, 16);
         else if (r < 95)
            len = $urandom_range(17, 40);
         else
            len = $urandom_range(60, 72);
         h = HEIGHT_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
         for (i = 0; i < len; i++) begin
            if (i > 0) h = pick_height(h);
            send_line(h, i == len - 1);
         end
         sent += len;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_single_line_lists();
      test_band_edges();
      test_zero_heights();
      test_extreme_heights();
      test_overflow_lists();
      test_random_lists();
      push = 1'b0;
      while (expected_lines.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_lines.size() == 0)
         $display("line_height_block_equalizer_core_test passed");
      else
         $display("line_height_block_equalizer_core_test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lhbe_pkg.sv
rtl/lhbe_front.sv
rtl/lhbe_queue.sv
rtl/lhbe_back.sv
rtl/line_height_block_equalizer_core.sv
tb/sv/line_height_block_equalizer_core_test.sv
